>>> rtl/swma_pkg.sv
package swma_pkg;

	localparam int WINDOW_MAX  = 64;
	localparam int SAMPLE_BITS = 16;
	localparam int WLEN_BITS   = 7;
	localparam int AVG_BITS    = 24;
	localparam int FRAC_BITS   = 8;

	localparam int COUNT_BITS = $clog2(WINDOW_MAX + 1);
	localparam int SLOT_BITS  = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
	localparam int SUM_BITS   = SAMPLE_BITS + COUNT_BITS;
	localparam int DIV_BITS   = SUM_BITS + FRAC_BITS;
	localparam int STEP_BITS  = $clog2(DIV_BITS);
	localparam int LEN_RESET  = (WINDOW_MAX < 64) ? WINDOW_MAX : 64;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_UPDATE,
		ST_START,
		ST_DIVIDE,
		ST_DELIVER
	} state_t;

	typedef struct packed {
		logic                  start;
		logic                  neg;
		logic [SUM_BITS-1:0]   mag;
		logic [COUNT_BITS-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic                       done;
		logic signed [AVG_BITS-1:0] quot;
	} div_rsp_t;

endpackage

>>> rtl/swma_ram.sv
module swma_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

>>> rtl/swma_div.sv
module swma_div (
	input  logic                clk,
	input  logic                arst_n,
	input  swma_pkg::div_req_t  req,
	output swma_pkg::div_rsp_t  rsp
);

	localparam logic [swma_pkg::STEP_BITS-1:0] LAST_STEP =
		swma_pkg::STEP_BITS'(swma_pkg::DIV_BITS - 1);

	logic                              busy_q;
	logic                              done_q;
	logic                              neg_q;
	logic [swma_pkg::STEP_BITS-1:0]    step_q;
	logic [swma_pkg::DIV_BITS-1:0]     quo_q;
	logic [swma_pkg::COUNT_BITS-1:0]   rem_q;
	logic [swma_pkg::COUNT_BITS-1:0]   div_q;
	logic [swma_pkg::COUNT_BITS:0]     trial;
	logic [swma_pkg::COUNT_BITS:0]     diff;
	logic                              fits;
	logic [swma_pkg::COUNT_BITS-1:0]   rem_next;
	logic [swma_pkg::AVG_BITS-1:0]     mag;

	// restoring division, one quotient bit per cycle
	assign trial    = {rem_q, quo_q[swma_pkg::DIV_BITS-1]};
	assign fits     = trial >= {1'b0, div_q};
	assign diff     = trial - {1'b0, div_q};
	assign rem_next = fits ? diff[swma_pkg::COUNT_BITS-1:0] : trial[swma_pkg::COUNT_BITS-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= busy_q && (step_q == LAST_STEP);
			if (req.start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + swma_pkg::STEP_BITS'(1);
				if (step_q == LAST_STEP) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= {req.mag, {swma_pkg::FRAC_BITS{1'b0}}};
			rem_q <= '0;
			div_q <= req.divisor;
			neg_q <= req.neg;
		end else if (busy_q) begin
			quo_q <= {quo_q[swma_pkg::DIV_BITS-2:0], fits};
			rem_q <= rem_next;
		end
	end

	// sign restored on the magnitude, so truncation is toward zero
	assign mag      = quo_q[swma_pkg::AVG_BITS-1:0];
	assign rsp.quot = neg_q ? -mag : mag;
	assign rsp.done = done_q;

endmodule

>>> rtl/sliding_window_moving_average.sv
// Sliding-window moving average of signed 16-bit samples.
// Input channel: sample with in_valid/in_ready; a transfer takes one sample.
// Output channel: average_q8 (window mean, Q.8, truncated toward zero) and
// samples_held with out_valid/out_ready; one result per input sample.
// Configuration: window_wr_en/window_wr_data write the window length
// (0 acts as 1, above 64 acts as 64) and clear the stored history; write
// only while no sample is in flight.
// One sample is processed at a time: a new sample is taken only once the
// result for the current one has been placed in the output register. The
// serial divider forms one quotient bit per cycle over the 31-bit scaled
// sum; ring read, sum update and divider load come before it.
// A finished result sits in an output register, so the next sample is taken
// while it waits; if the receiver still stalls when the next result is
// ready, the block holds that result and takes no input until it is gone.
// Reset: window length 64, empty history, both channels idle. The sample
// ring needs no clearing pass; unwritten entries are never used.
module sliding_window_moving_average (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   window_wr_en,
	input  logic [swma_pkg::WLEN_BITS-1:0]         window_wr_data,
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  logic signed [swma_pkg::SAMPLE_BITS-1:0] sample,
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output logic signed [swma_pkg::AVG_BITS-1:0]   average_q8,
	output logic [swma_pkg::COUNT_BITS-1:0]        samples_held
);

	swma_pkg::state_t                         state_q;
	swma_pkg::state_t                         state_next;
	logic [swma_pkg::COUNT_BITS-1:0]          len_q;
	logic [swma_pkg::COUNT_BITS-1:0]          len_wr;
	logic [swma_pkg::COUNT_BITS-1:0]          fill_q;
	logic [swma_pkg::SLOT_BITS-1:0]           slot_q;
	logic [swma_pkg::COUNT_BITS-1:0]          slot_plus;
	logic signed [swma_pkg::SUM_BITS-1:0]     sum_q;
	logic signed [swma_pkg::SUM_BITS-1:0]     sum_next;
	logic signed [swma_pkg::SUM_BITS-1:0]     old_ext;
	logic signed [swma_pkg::SAMPLE_BITS-1:0]  sample_q;
	logic signed [swma_pkg::SAMPLE_BITS-1:0]  ring_rd;
	logic                                     full;
	logic                                     accept;
	logic                                     ram_we;
	logic                                     out_load;
	logic                                     out_valid_q;
	logic signed [swma_pkg::AVG_BITS-1:0]     avg_q;
	logic [swma_pkg::COUNT_BITS-1:0]          held_q;
	swma_pkg::div_req_t                       div_req;
	swma_pkg::div_rsp_t                       div_rsp;

	always_comb begin
		if (window_wr_data == '0) begin
			len_wr = swma_pkg::COUNT_BITS'(1);
		end else if (int'(window_wr_data) > swma_pkg::WINDOW_MAX) begin
			len_wr = swma_pkg::COUNT_BITS'(swma_pkg::WINDOW_MAX);
		end else begin
			len_wr = swma_pkg::COUNT_BITS'(window_wr_data);
		end
	end

	assign full      = fill_q >= len_q;
	assign old_ext   = full ? swma_pkg::SUM_BITS'(ring_rd) : '0;
	assign sum_next  = sum_q - old_ext + swma_pkg::SUM_BITS'(sample_q);
	assign slot_plus = swma_pkg::COUNT_BITS'(slot_q) + swma_pkg::COUNT_BITS'(1);
	assign accept    = in_valid && in_ready;

	swma_ram #(
		.WIDTH(swma_pkg::SAMPLE_BITS),
		.DEPTH(swma_pkg::WINDOW_MAX)
	) u_ring (
		.clk    (clk),
		.wr_en  (ram_we),
		.wr_addr(slot_q),
		.wr_data(sample_q),
		.rd_addr(slot_q),
		.rd_data(ring_rd)
	);

	assign div_req.start   = (state_q == swma_pkg::ST_START);
	assign div_req.neg     = sum_q[swma_pkg::SUM_BITS-1];
	assign div_req.mag     = sum_q[swma_pkg::SUM_BITS-1] ? -sum_q : sum_q;
	assign div_req.divisor = fill_q;

	swma_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (div_req),
		.rsp   (div_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= swma_pkg::ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	always_comb begin
		state_next = state_q;
		in_ready   = 1'b0;
		ram_we     = 1'b0;
		out_load   = 1'b0;
		case (state_q)
			swma_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_next = swma_pkg::ST_UPDATE;
				end
			end
			swma_pkg::ST_UPDATE: begin
				ram_we     = 1'b1;
				state_next = swma_pkg::ST_START;
			end
			swma_pkg::ST_START: begin
				state_next = swma_pkg::ST_DIVIDE;
			end
			swma_pkg::ST_DIVIDE: begin
				if (div_rsp.done) begin
					if (!out_valid_q || out_ready) begin
						out_load   = 1'b1;
						state_next = swma_pkg::ST_IDLE;
					end else begin
						state_next = swma_pkg::ST_DELIVER;
					end
				end
			end
			swma_pkg::ST_DELIVER: begin
				if (!out_valid_q || out_ready) begin
					out_load   = 1'b1;
					state_next = swma_pkg::ST_IDLE;
				end
			end
			default: begin
				state_next = swma_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q       <= swma_pkg::COUNT_BITS'(swma_pkg::LEN_RESET);
			fill_q      <= '0;
			slot_q      <= '0;
			sum_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (window_wr_en) begin
				len_q  <= len_wr;
				fill_q <= '0;
				slot_q <= '0;
				sum_q  <= '0;
			end else if (state_q == swma_pkg::ST_UPDATE) begin
				sum_q <= sum_next;
				if (!full) begin
					fill_q <= fill_q + swma_pkg::COUNT_BITS'(1);
				end
				if (slot_plus >= len_q) begin
					slot_q <= '0;
				end else begin
					slot_q <= slot_plus[swma_pkg::SLOT_BITS-1:0];
				end
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			sample_q <= sample;
		end
		if (out_load) begin
			avg_q  <= div_rsp.quot;
			held_q <= fill_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign average_q8   = avg_q;
	assign samples_held = held_q;

endmodule

>>> rtl/swma_chk.sv
module swma_chk (
	input logic                                    clk,
	input logic                                    arst_n,
	input logic                                    in_valid,
	input logic                                    in_ready,
	input logic                                    out_valid,
	input logic                                    out_ready,
	input logic signed [swma_pkg::AVG_BITS-1:0]    average_q8,
	input logic [swma_pkg::COUNT_BITS-1:0]         samples_held
);

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(average_q8) && $stable(samples_held))
		else $error("result changed while stalled");

	a_held_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> samples_held != '0 &&
			samples_held <= swma_pkg::COUNT_BITS'(swma_pkg::WINDOW_MAX))
		else $error("samples_held out of range");

	// one sample in flight at a time
	a_in_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken while busy");

	// a new result frees the input side
	a_result_frees: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> in_ready)
		else $error("input not ready after result");

endmodule

bind sliding_window_moving_average swma_chk u_swma_chk (.*);
